// ----- rtl/assert_macros.svh -----
// Assertion macros used by the deframer parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a plain property on every clock edge outside reset.
`define LPMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define LPMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define LPMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lpmd_pkg.sv -----
// Types and constants for the length-prefixed message deframer.
package lpmd_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;
    localparam logic [2:0]  HDR_BYTES = 3'd5;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_IGNORE  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT_HDR = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        compressed_flag;
        logic [31:0] message_length;
        logic        message_done;
        t_status     status;
    } t_result;

endpackage

// ----- rtl/lpmd_regs.sv -----
// Configuration register file of the deframer (APB-style access).
module lpmd_regs
    import lpmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [31:0]       o_max_len
);

    logic [31:0] r_max_len;
    logic        sel_max;

    // Only the word index is decoded; the byte offset bits are ignored.
    assign sel_max = (paddr[ADDR_W-1:2] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && sel_max) begin
            r_max_len <= pwdata;
        end
    end

    assign prdata    = sel_max ? r_max_len : 32'd0;
    assign pready    = 1'b1;
    assign o_max_len = r_max_len;

endmodule

// ----- rtl/lpmd_parser.sv -----
// Header and payload parser: frame state and the result for one word.
module lpmd_parser
    import lpmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    input  logic [31:0] i_max_len,
    output logic        o_res_valid,
    output t_result     o_res
);

`include "assert_macros.svh"

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_flag,    n_flag;
    logic [31:0] r_len,     n_len;
    logic [31:0] r_rem,     n_rem;

    logic [2:0]  hdr_cnt_inc;
    logic [31:0] hdr_len;
    logic        hdr_flag;
    logic        hdr_full;
    logic        too_large;
    logic        len_zero;
    logic [31:0] rem_dec;
    logic        rem_zero;

    assign hdr_cnt_inc = r_hdr_cnt + 3'd1;
    // The first header byte is the flag; the next four shift in the length MSB first.
    assign hdr_len   = (r_hdr_cnt == 3'd0) ? r_len : {r_len[23:0], i_data_byte};
    assign hdr_flag  = (r_hdr_cnt == 3'd0) ? (i_data_byte != 8'd0) : r_flag;
    assign hdr_full  = (hdr_cnt_inc >= HDR_BYTES);
    assign too_large = (hdr_len > i_max_len);
    assign len_zero  = (hdr_len == 32'd0);
    assign rem_dec   = r_rem - 32'd1;
    assign rem_zero  = (rem_dec == 32'd0);

    // Next frame state.
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_flag    = r_flag;
        n_len     = r_len;
        n_rem     = r_rem;
        unique case (r_phase)
            PH_HEADER: begin
                n_hdr_cnt = hdr_cnt_inc;
                n_flag    = hdr_flag;
                n_len     = hdr_len;
                if (hdr_full) begin
                    if (too_large || len_zero) begin
                        n_phase = PH_IGNORE;
                    end else if (!i_buffer_end) begin
                        n_rem   = hdr_len;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_rem = rem_dec;
                if (rem_zero) begin
                    n_phase = PH_IGNORE;
                end
            end
            default: begin
            end
        endcase
        // Every buffer is parsed on its own.
        if (i_buffer_end) begin
            n_phase   = PH_HEADER;
            n_hdr_cnt = 3'd0;
            n_flag    = 1'b0;
            n_len     = 32'd0;
            n_rem     = 32'd0;
        end
    end

    // Result for the current word.
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '{payload_byte: 8'd0, has_byte: 1'b0, compressed_flag: 1'b0,
                        message_length: 32'd0, message_done: 1'b0, status: ST_OK};
        unique case (r_phase)
            PH_HEADER: begin
                if (hdr_full) begin
                    if (too_large) begin
                        o_res_valid           = 1'b1;
                        o_res.compressed_flag = hdr_flag;
                        o_res.message_length  = hdr_len;
                        o_res.message_done    = 1'b1;
                        o_res.status          = ST_TOO_LARGE;
                    end else if (len_zero) begin
                        o_res_valid           = 1'b1;
                        o_res.compressed_flag = hdr_flag;
                        o_res.message_done    = 1'b1;
                    end else if (i_buffer_end) begin
                        o_res_valid           = 1'b1;
                        o_res.compressed_flag = hdr_flag;
                        o_res.message_length  = hdr_len;
                        o_res.message_done    = 1'b1;
                        o_res.status          = ST_TRUNCATED;
                    end
                end else if (i_buffer_end) begin
                    o_res_valid        = 1'b1;
                    o_res.message_done = 1'b1;
                    o_res.status       = ST_SHORT_HDR;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid           = 1'b1;
                o_res.payload_byte    = i_data_byte;
                o_res.has_byte        = 1'b1;
                o_res.compressed_flag = r_flag;
                o_res.message_length  = r_len;
                o_res.message_done    = rem_zero || i_buffer_end;
                o_res.status          = (!rem_zero && i_buffer_end) ? ST_TRUNCATED : ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= 3'd0;
            r_flag    <= 1'b0;
            r_len     <= 32'd0;
            r_rem     <= 32'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_flag    <= n_flag;
            r_len     <= n_len;
            r_rem     <= n_rem;
        end
    end

    `LPMD_ASSERT_IMP(a_byte_only_in_payload, o_res_valid && o_res.has_byte,
        r_phase == PH_PAYLOAD, "payload byte produced outside the payload phase")
    `LPMD_ASSERT_NEXT(a_buffer_end_restarts, i_step && i_buffer_end,
        r_phase == PH_HEADER && r_hdr_cnt == 3'd0 && r_len == 32'd0,
        "buffer end did not return the parser to header collection")
    `LPMD_ASSERT(a_payload_count_live, r_phase != PH_PAYLOAD || r_rem != 32'd0,
        "payload phase entered with no bytes remaining")

endmodule

// ----- rtl/length_prefixed_message_deframer.sv -----
// Top level of the length-prefixed message deframer.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_data_byte, i_buffer_end
//   output    out        o_out_valid / i_out_ready o_payload_byte .. o_status
//   config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// One word is accepted per clock unless the output stalls; it is held in the input
// register, and its result is written to the result register when the pipeline
// advances, so o_out_valid comes from the result register.
// Words update frame state; results come from payload and message-ending header words.
// A held word advances whenever the result register is empty or being taken.
// Reset is synchronous and restores the maximum length to 4194304 and header collection.
module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_buffer_end,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_payload_byte,
    output logic              o_has_byte,
    output logic              o_compressed_flag,
    output logic [31:0]       o_message_length,
    output logic              o_message_done,
    output logic [1:0]        o_status,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        advance;
    logic        res_valid;
    t_result     res;
    logic [31:0] max_len;

    lpmd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    lpmd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_data_byte  (r_in_byte),
        .i_buffer_end (r_in_last),
        .i_max_len    (max_len),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= advance && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_buffer_end;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_has_byte        = r_out.has_byte;
    assign o_compressed_flag = r_out.compressed_flag;
    assign o_message_length  = r_out.message_length;
    assign o_message_done    = r_out.message_done;
    assign o_status          = r_out.status;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the length-prefixed message deframer.
module testbench
    import lpmd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] REG_MAX_LEN = '0;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } t_rx_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_data_byte = '0;
    logic              i_buffer_end = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [7:0]        o_payload_byte;
    logic              o_has_byte;
    logic              o_compressed_flag;
    logic [31:0]       o_message_length;
    logic              o_message_done;
    logic [1:0]        o_status;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    length_prefixed_message_deframer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_data_byte(i_data_byte), .i_buffer_end(i_buffer_end),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_payload_byte(o_payload_byte), .o_has_byte(o_has_byte),
        .o_compressed_flag(o_compressed_flag), .o_message_length(o_message_length),
        .o_message_done(o_message_done), .o_status(o_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_rx_word    pending_words[$];
    t_result     expected_results[$];

    // Shadow copy of the deframer state and its length limit.
    logic [31:0] max_len_cfg = MAX_LEN_RESET;
    t_phase      frame_phase = PH_HEADER;
    logic [2:0]  hdr_count = '0;
    logic [31:0] hdr_length = '0;
    logic [31:0] bytes_left = '0;
    logic        hdr_flag = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned buffers_built = 0;
    int unsigned limits_used = 1;
    int unsigned status_count[4] = '{0, 0, 0, 0};
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_done = 0;
    bit          word_taken = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic string format_result(t_result r);
        return $sformatf("byte=%02h has=%b flag=%b len=%0d done=%b status=%0d",
                         r.payload_byte, r.has_byte, r.compressed_flag,
                         r.message_length, r.message_done, r.status);
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic t_result make_result(logic [7:0] b, logic has, logic flag,
                                            logic [31:0] len, logic done, t_status st);
        t_result r;
        r.payload_byte = b;
        r.has_byte = has;
        r.compressed_flag = flag;
        r.message_length = len;
        r.message_done = done;
        r.status = st;
        return r;
    endfunction

    // Advances the shadow frame state by one accepted word.
    task automatic predict_word(logic [7:0] b, logic last);
        t_result r;
        bit      produced;
        produced = 1'b0;
        r = '0;
        case (frame_phase)
            PH_HEADER: begin
                if (hdr_count == 3'd0) begin
                    hdr_flag = (b != 8'd0);
                end else begin
                    hdr_length = {hdr_length[23:0], b};
                end
                hdr_count = hdr_count + 3'd1;
                if (hdr_count >= HDR_BYTES) begin
                    produced = 1'b1;
                    if (hdr_length > max_len_cfg) begin
                        r = make_result(8'd0, 1'b0, hdr_flag, hdr_length, 1'b1, ST_TOO_LARGE);
                        frame_phase = PH_IGNORE;
                    end else if (hdr_length == 32'd0) begin
                        r = make_result(8'd0, 1'b0, hdr_flag, 32'd0, 1'b1, ST_OK);
                        frame_phase = PH_IGNORE;
                    end else if (last) begin
                        r = make_result(8'd0, 1'b0, hdr_flag, hdr_length, 1'b1, ST_TRUNCATED);
                    end else begin
                        produced = 1'b0;
                        bytes_left = hdr_length;
                        frame_phase = PH_PAYLOAD;
                    end
                end else if (last) begin
                    produced = 1'b1;
                    r = make_result(8'd0, 1'b0, 1'b0, 32'd0, 1'b1, ST_SHORT_HDR);
                end
            end
            PH_PAYLOAD: begin
                produced = 1'b1;
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0) begin
                    r = make_result(b, 1'b1, hdr_flag, hdr_length, 1'b1, ST_OK);
                    frame_phase = PH_IGNORE;
                end else if (last) begin
                    r = make_result(b, 1'b1, hdr_flag, hdr_length, 1'b1, ST_TRUNCATED);
                end else begin
                    r = make_result(b, 1'b1, hdr_flag, hdr_length, 1'b0, ST_OK);
                end
            end
            default: begin
            end
        endcase
        // The end of a buffer always restarts header collection.
        if (last) begin
            frame_phase = PH_HEADER;
            hdr_count = '0;
            hdr_length = '0;
            bytes_left = '0;
            hdr_flag = 1'b0;
        end
        if (produced) begin
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got = make_result(o_payload_byte, o_has_byte, o_compressed_flag,
                          o_message_length, o_message_done, t_status'(o_status));
        if (expected_results.size() == 0) begin
            report_error({"result with nothing expected: ", format_result(got)});
        end else begin
            want = expected_results.pop_front();
            results_checked++;
            status_count[int'(want.status)]++;
            if (got.payload_byte !== want.payload_byte || got.has_byte !== want.has_byte ||
                got.compressed_flag !== want.compressed_flag ||
                got.message_length !== want.message_length ||
                got.message_done !== want.message_done || got.status !== want.status) begin
                report_error({"expected ", format_result(want), " got ", format_result(got)});
            end
        end
    endtask

    // Monitor: outputs are checked before the accepted word is predicted, and a
    // result never leaves the block in the cycle its word enters.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end else begin
            word_taken = i_rst_n && i_in_valid && o_in_ready;
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_result();
            end
            if (word_taken) begin
                words_sent++;
                predict_word(i_data_byte, i_buffer_end);
            end
        end
    end

    // Driver: offers words in bursts with random gaps between them.
    always @(negedge i_clk) begin : word_driver
        int unsigned burst_left;
        int unsigned gap_left;
        t_rx_word    w;
        logic        next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!i_in_valid || word_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].hold && expected_results.size() != 0)) begin
                w = pending_words.pop_front();
                i_data_byte <= w.data;
                i_buffer_end <= w.last;
                next_valid = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // Receiver: ready follows a random mode that is re-picked when its run ends,
    // with an occasional long hold-off on request.
    always @(negedge i_clk) begin : result_sink
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned ready_mode;
        logic        next_ready;
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (long_holds_done < long_holds_asked) begin
            long_holds_done++;
            hold_left = LONG_HOLD_CYCLES;
            next_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (ready_mode)
                0: next_ready = 1'b1;
                1: next_ready = $urandom_range(0, 1);
                2: next_ready = ($urandom_range(0, 3) != 0);
                default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
        i_out_ready <= next_ready;
    end

    function automatic void push_word(logic [7:0] b, logic last, logic hold);
        t_rx_word w;
        w.data = b;
        w.last = last;
        w.hold = hold;
        pending_words.insert(pending_words.size(), w);
    endfunction

    // Queues one buffer: the first hdr_n header bytes, body_n payload bytes and
    // trail_n trailing bytes. The final word carries the buffer end mark.
    function automatic int unsigned add_buffer(logic [7:0] flag_b, logic [31:0] len,
                                               int unsigned hdr_n, int unsigned body_n,
                                               int unsigned trail_n, bit hold);
        logic [7:0]  hdr[5];
        int unsigned total;
        int unsigned idx;
        hdr[0] = flag_b;
        hdr[1] = len[31:24];
        hdr[2] = len[23:16];
        hdr[3] = len[15:8];
        hdr[4] = len[7:0];
        total = hdr_n + body_n + trail_n;
        for (idx = 0; idx < total; idx++) begin
            push_word((idx < hdr_n) ? hdr[idx] : 8'($urandom), idx == total - 1,
                      hold && idx == 0);
        end
        buffers_built++;
        return total;
    endfunction

    function automatic logic [31:0] pick_length(logic [31:0] lim);
        logic [31:0] top;
        if (lim == 32'd0) begin
            return 32'd0;
        end
        top = (lim < 32'd48) ? lim : 32'd48;
        if ($urandom_range(0, 7) == 0) begin
            return top;
        end
        if ($urandom_range(0, 3) != 0 && top > 32'd12) begin
            top = 32'd12;
        end
        return $urandom_range(1, top);
    endfunction

    function automatic logic [31:0] pick_oversize(logic [31:0] lim);
        case ($urandom_range(0, 3))
            0: return lim + 32'd1;
            1: return 32'hFFFF_FFFF;
            default: return lim + 32'd1 + ($urandom % (~lim));
        endcase
    endfunction

    function automatic logic [7:0] pick_flag();
        return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom);
    endfunction

    // Mostly well-formed messages with random content; the rest are errors or empty messages.
    function automatic void add_random_buffers(int unsigned word_budget);
        int unsigned added;
        int unsigned kind;
        bit          hold;
        logic [31:0] len;
        added = 0;
        while (added < word_budget) begin
            kind = $urandom_range(0, 99);
            hold = ($urandom_range(0, 19) == 0);
            len = pick_length(max_len_cfg);
            if (kind >= 80 && kind < 88 && max_len_cfg == 32'hFFFF_FFFF) begin
                kind = 0;
            end
            if (kind < 70) begin
                added += add_buffer(pick_flag(), len, 5, len,
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                                    hold);
            end else if (kind < 80) begin
                added += add_buffer(pick_flag(), len, 5,
                                    (len == 0) ? 0 : $urandom_range(0, len - 1), 0, hold);
            end else if (kind < 88) begin
                added += add_buffer(pick_flag(), pick_oversize(max_len_cfg), 5, 0,
                                    $urandom_range(0, 3), hold);
            end else if (kind < 94) begin
                added += add_buffer(pick_flag(), 32'($urandom), $urandom_range(1, 4), 0, 0,
                                    hold);
            end else begin
                added += add_buffer(pick_flag(), 32'd0, 5, 0, $urandom_range(0, 3), hold);
            end
        end
    endfunction

    // Waits until every queued word is taken and every result has come out.
    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_length(logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MAX_LEN;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        max_len_cfg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value) begin
            report_error($sformatf("max length reads back %h, wrote %h", prdata, value));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        limits_used++;
    endtask

    initial begin : stimulus
        int unsigned unused;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers under the reset limit: a one-word short header, an
        // empty payload with a trailing word, an oversize length, a header that
        // ends the buffer, a complete one-byte message and a truncated one.
        unused = add_buffer(8'hFF, 32'd0, 1, 0, 0, 1'b0);
        unused = add_buffer(8'h00, 32'd0, 5, 0, 1, 1'b0);
        unused = add_buffer(8'h80, 32'hFFFF_FFFF, 5, 0, 0, 1'b0);
        unused = add_buffer(8'h01, 32'd3, 5, 0, 0, 1'b0);
        unused = add_buffer(8'h00, 32'd1, 5, 1, 0, 1'b0);
        unused = add_buffer(8'h7F, 32'd4, 5, 1, 0, 1'b0);
        add_random_buffers(300);
        wait_idle();

        write_max_length(32'hFFFF_FFFF);
        long_holds_asked++;
        add_random_buffers(450);
        wait_idle();

        write_max_length(32'd0);
        add_random_buffers(150);
        wait_idle();

        write_max_length(32'd16);
        long_holds_asked++;
        add_random_buffers(450);
        wait_idle();

        write_max_length(32'd1);
        add_random_buffers(350);
        wait_idle();

        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Sent %0d words in %0d buffers under %0d length limits; checked %0d results",
                 words_sent, buffers_built, limits_used, results_checked);
        $display("Statuses ok/short/too large/truncated: %0d/%0d/%0d/%0d; %0d errors",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
